>>> hw/rtl/vfgf_pkg.sv
// shared types, constants and field layouts for the voice frame gap filler
package vfgf_pkg;

    // fixed field widths
    localparam int SLOT_W   = 5;
    localparam int CFG_W    = 5;
    localparam int SEQB_W   = 8;
    localparam int KIND_W   = 2;
    localparam int ADD_W    = SLOT_W + 1;

    // sequence defaults and limits
    localparam int SEQ_PERIOD_DEF = 21;
    localparam logic [SLOT_W-1:0] MAX_FILL = SLOT_W'(20);
    localparam int END_BIT  = 6;

    // register reset values
    localparam logic [CFG_W-1:0] SILENCE_THR_RST = CFG_W'(2);
    localparam logic [CFG_W-1:0] DROP_LIMIT_RST  = CFG_W'(18);

    // register indexes
    localparam logic REG_SILENCE_THR = 1'b0;
    localparam logic REG_DROP_LIMIT  = 1'b1;

    // input word kinds
    localparam logic IN_HEADER = 1'b0;
    localparam logic IN_DATA   = 1'b1;

    // result frame kinds
    localparam logic [KIND_W-1:0] FK_RECV    = 2'd0;
    localparam logic [KIND_W-1:0] FK_SILENCE = 2'd1;
    localparam logic [KIND_W-1:0] FK_REPEAT  = 2'd2;
    localparam logic [KIND_W-1:0] FK_END     = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [SEQB_W-1:0] seq_byte;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0] frame_kind;
        logic [SLOT_W-1:0] slot;
        logic              sync_slot;
        logic              last;
    } t_out_word;

    // operands for the shared modulo adder
    typedef struct packed {
        logic [ADD_W-1:0] a;
        logic [ADD_W-1:0] b;
    } t_add_op;

endpackage

>>> hw/rtl/vfgf_mod_add.sv
// shared modulo-period adder used for gap measurement and slot advance
module vfgf_mod_add #(
    parameter int SEQ_PERIOD = vfgf_pkg::SEQ_PERIOD_DEF
) (
    input  vfgf_pkg::t_add_op              i_op,
    output logic [vfgf_pkg::SLOT_W-1:0]    o_sum
);
    import vfgf_pkg::*;

    localparam logic [ADD_W:0] PERIOD = (ADD_W+1)'(SEQ_PERIOD);

    logic [ADD_W:0] raw_sum;
    logic [ADD_W:0] wrapped;

    // add, then fold back once into the period
    always_comb begin
        raw_sum = {1'b0, i_op.a} + {1'b0, i_op.b};
        wrapped = (raw_sum >= PERIOD) ? (raw_sum - PERIOD) : raw_sum;
        o_sum   = wrapped[SLOT_W-1:0];
    end

endmodule

>>> hw/rtl/vfgf_seq.sv
// sequencer: slot tracking, gap decision and result emission
module vfgf_seq #(
    parameter int SEQ_PERIOD = vfgf_pkg::SEQ_PERIOD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  vfgf_pkg::t_in_word            i_in_word,
    input  logic [vfgf_pkg::CFG_W-1:0]    i_silence_thr,
    input  logic [vfgf_pkg::CFG_W-1:0]    i_drop_limit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output vfgf_pkg::t_out_word           o_out_word,
    output vfgf_pkg::t_add_op             o_add_op,
    input  logic [vfgf_pkg::SLOT_W-1:0]   i_add_sum
);
    import vfgf_pkg::*;

    localparam logic [ADD_W-1:0] PERIOD = ADD_W'(SEQ_PERIOD);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GAP,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [SLOT_W-1:0]   r_exp;
    logic [SLOT_W-1:0]   r_num;
    logic [SLOT_W-1:0]   r_remain;
    logic [KIND_W-1:0]   r_fill;
    logic                r_out_valid;
    t_out_word           r_out;

    logic                in_acc;
    logic                out_acc;
    logic [SLOT_W-1:0]   in_num;
    logic [SLOT_W-1:0]   n_remain;
    logic                gap_drop;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_acc  = r_out_valid && i_out_ready;
    assign in_num   = i_in_word.seq_byte[SLOT_W-1:0];
    assign n_remain = r_remain - SLOT_W'(1);
    assign gap_drop = ({1'b0, i_add_sum} > {1'b0, i_drop_limit}) || (i_add_sum > MAX_FILL);

    // operand select: gap in the measure step, slot + 1 otherwise
    always_comb begin
        if (r_state == S_GAP) begin
            o_add_op.a = {1'b0, r_num};
            o_add_op.b = PERIOD - {1'b0, r_exp};
        end else begin
            o_add_op.a = {1'b0, r_exp};
            o_add_op.b = ADD_W'(1);
        end
    end

    // state, slot counter and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_word.kind == IN_HEADER) begin
                            r_exp <= '0;
                        end else if (i_in_word.seq_byte[END_BIT]) begin
                            r_out.frame_kind <= FK_END;
                            r_out.slot       <= r_exp;
                            r_out.sync_slot  <= 1'b0;
                            r_out.last       <= 1'b1;
                            r_out_valid      <= 1'b1;
                            r_state          <= S_EMIT;
                        end else if ({1'b0, in_num} < PERIOD) begin
                            r_num   <= in_num;
                            r_state <= S_GAP;
                        end
                    end
                end
                S_GAP: begin
                    if (gap_drop) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_remain <= i_add_sum;
                        r_fill   <= ({1'b0, i_add_sum} > {1'b0, i_silence_thr}) ?
                                    FK_SILENCE : FK_REPEAT;
                        r_out.slot      <= r_exp;
                        r_out.sync_slot <= (r_exp == '0);
                        if (i_add_sum == '0) begin
                            r_out.frame_kind <= FK_RECV;
                            r_out.last       <= 1'b1;
                        end else begin
                            r_out.frame_kind <= ({1'b0, i_add_sum} > {1'b0, i_silence_thr}) ?
                                                FK_SILENCE : FK_REPEAT;
                            r_out.last       <= 1'b0;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_acc) begin
                        if (r_out.frame_kind != FK_END) begin
                            r_exp <= i_add_sum;
                        end
                        if (r_out.last) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_remain        <= n_remain;
                            r_out.slot      <= i_add_sum;
                            r_out.sync_slot <= (i_add_sum == '0);
                            if (n_remain == '0) begin
                                r_out.frame_kind <= FK_RECV;
                                r_out.last       <= 1'b1;
                            end else begin
                                r_out.frame_kind <= r_fill;
                                r_out.last       <= 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

>>> hw/rtl/voice_frame_gap_filler_top.sv
// A data frame first passes the gap step, then its first result is registered;
// an end frame's result is registered on acceptance; results then follow one per
// cycle while taken. A frame occupies the block until its last result is taken,
// a header or dropped frame only the accept and gap steps; one modulo adder is shared.
// Reset (synchronous, active low): expected slot 0, silence threshold 2,
// drop limit 18, no result pending, input ready.
module voice_frame_gap_filler_top #(
    parameter int SEQ_PERIOD = vfgf_pkg::SEQ_PERIOD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  vfgf_pkg::t_in_word          i_word,
    output logic                        o_valid,
    input  logic                        i_ready,
    output vfgf_pkg::t_out_word         o_word,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [vfgf_pkg::CFG_W-1:0]  i_cfg_data
);
    import vfgf_pkg::*;

    logic [CFG_W-1:0]  r_silence_thr;
    logic [CFG_W-1:0]  r_drop_limit;
    t_add_op           add_op;
    logic [SLOT_W-1:0] add_sum;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_thr <= SILENCE_THR_RST;
            r_drop_limit  <= DROP_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SILENCE_THR: r_silence_thr <= i_cfg_data;
                REG_DROP_LIMIT:  r_drop_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    vfgf_seq #(
        .SEQ_PERIOD (SEQ_PERIOD)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .o_in_ready    (o_ready),
        .i_in_word     (i_word),
        .i_silence_thr (r_silence_thr),
        .i_drop_limit  (r_drop_limit),
        .o_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .o_out_word    (o_word),
        .o_add_op      (add_op),
        .i_add_sum     (add_sum)
    );

    // shared modulo adder
    vfgf_mod_add #(
        .SEQ_PERIOD (SEQ_PERIOD)
    ) u_add (
        .i_op  (add_op),
        .o_sum (add_sum)
    );

endmodule

>>> hw/rtl/vfgf_checker.sv
// port-level checks for the voice frame gap filler, bound to the top level
module vfgf_checker #(
    parameter int SEQ_PERIOD = vfgf_pkg::SEQ_PERIOD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_ready,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  vfgf_pkg::t_out_word         o_word
);
    import vfgf_pkg::*;

    localparam logic [SLOT_W:0] PERIOD = (SLOT_W+1)'(SEQ_PERIOD);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word))
        else $error("result word changed while stalled");

    // no new word is taken while results are pending
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while results pending");

    // every slot lies inside the period
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_word.slot} < PERIOD))
        else $error("slot outside sequence period");

    // sync flag marks slot zero of non-end frames
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.sync_slot == ((o_word.slot == '0) && (o_word.frame_kind != FK_END))))
        else $error("sync flag mismatch");

    // an end frame is always marked as the final result
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word.frame_kind == FK_END) |-> o_word.last)
        else $error("end frame without last");

endmodule

bind voice_frame_gap_filler_top vfgf_checker #(
    .SEQ_PERIOD (SEQ_PERIOD)
) u_vfgf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_word     (o_word)
);
